// ===== design/tlptm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlptm_pkg
// Shared widths, codes and constants for the two-level page table manager.
// ----------------------------------------------------------------------------
package tlptm_pkg;

    // Address split: directory index, table index, page offset
    localparam int PAGE_SHIFT  = 12;
    localparam int DIR_IDX_W   = 10;
    localparam int TAB_IDX_W   = 10;
    localparam int FRAME_W     = 20;
    localparam int ADDR_W      = 32;
    localparam int ATTR_W      = 12;
    localparam int CFG_IDX_W   = 3;

    // Default size of the page table pool
    localparam int MAX_TABLES_DEF = 16;

    // Item kinds
    localparam logic [1:0] MODE_MAP   = 2'd0;
    localparam logic [1:0] MODE_UNMAP = 2'd1;
    localparam logic [1:0] MODE_FAULT = 2'd2;

    // Result codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_OUTSIDE     = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED   = 2'd3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_POOL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_POOL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OD_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OD_END      = 3'd4;

    // Reset values
    localparam logic [FRAME_W-1:0] USER_POOL_RST = 20'd1024;
    localparam logic [ADDR_W-1:0]  OD_START_RST  = 32'h0700_0000;
    localparam logic [ADDR_W-1:0]  OD_END_RST    = 32'h0700_0FFF;

    // Attributes of an on-demand page: present and writable
    localparam logic [ATTR_W-1:0]  ATTR_USER_RW  = 12'h003;

endpackage

// ===== design/two_level_page_table_manager_top.sv =====
// A fault outside the window, an unmap through an absent directory entry or a full pool
// is answered from the directory read; a map, fault or unmap on an existing table also
// reads or writes the page entry; when a new table is allocated, its 1024 entries are
// first cleared through the single table memory write port.
// A new item is taken only once the last one is done. After reset the input stalls
// while the directory memory is cleared one entry a cycle.
// ----------------------------------------------------------------------------
// two_level_page_table_manager_top
// Holds one page directory and a pool of page tables in two synchronous
// memories and serves map, unmap and on-demand fault beats one at a time.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_top #(
    parameter int MAX_TABLES = tlptm_pkg::MAX_TABLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [tlptm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tlptm_pkg::ADDR_W-1:0]      i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [tlptm_pkg::ADDR_W-1:0]      i_virt_addr,
    input  logic [tlptm_pkg::ADDR_W-1:0]      i_phys_addr,
    input  logic [tlptm_pkg::ATTR_W-1:0]      i_page_attrs,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [tlptm_pkg::ADDR_W-1:0]      o_phys_out,
    output logic                              o_table_created
);
    import tlptm_pkg::*;

    // Slot number of a table in the pool, and count of tables in use
    localparam int SLOT_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int TIU_W  = $clog2(MAX_TABLES + 1);
    localparam int TAB_AW = SLOT_W + TAB_IDX_W;
    localparam int DIR_DEPTH = 1 << DIR_IDX_W;
    localparam int TAB_DEPTH = MAX_TABLES << TAB_IDX_W;

    // Sequencer states
    localparam logic [2:0] S_INIT = 3'd0;  // clear directory after reset
    localparam logic [2:0] S_IDLE = 3'd1;  // wait for an input beat
    localparam logic [2:0] S_DIR  = 3'd2;  // directory entry available
    localparam logic [2:0] S_CLR  = 3'd3;  // zero a freshly allocated table
    localparam logic [2:0] S_TAB  = 3'd4;  // page entry available (unmap)
    localparam logic [2:0] S_WR   = 3'd5;  // write page entry (map, fault)
    localparam logic [2:0] S_DONE = 3'd6;  // result waits for output register

    // Directory word: present bit on top, pool slot of the table below.
    // The table frame itself is never read back, so it is not kept.
    logic [SLOT_W:0]           r_dir_mem [DIR_DEPTH];
    logic [ADDR_W-1:0]         r_tab_mem [TAB_DEPTH];
    logic [SLOT_W:0]           r_dir_q;
    logic [ADDR_W-1:0]         r_tab_q;

    logic [2:0]                r_state, n_state;
    logic [TAB_IDX_W-1:0]      r_cnt;
    logic [TIU_W-1:0]          r_tiu;
    logic [FRAME_W-1:0]        r_next_user;
    logic [ADDR_W-1:0]         r_od_start;
    logic [ADDR_W-1:0]         r_od_end;

    // Captured item
    logic [1:0]                r_mode;
    logic [ADDR_W-1:0]         r_va;
    logic [ADDR_W-1:0]         r_pa;
    logic [ATTR_W-1:0]         r_attrs;
    logic [SLOT_W-1:0]         r_slot;
    logic                      r_made;

    // Parked result and output register
    logic [1:0]                r_res_status;
    logic [ADDR_W-1:0]         r_res_phys;
    logic                      r_res_made;
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [ADDR_W-1:0]         r_out_phys;
    logic                      r_out_made;

    logic                      in_acc;
    logic                      out_free;
    logic                      dir_present;
    logic [SLOT_W-1:0]         dir_slot;
    logic                      pool_full;
    logic                      in_window;
    logic [DIR_IDX_W-1:0]      va_di;
    logic [TAB_IDX_W-1:0]      va_ti;

    logic                      dir_we;
    logic [DIR_IDX_W-1:0]      dir_waddr;
    logic [SLOT_W:0]           dir_wdata;
    logic                      tab_we;
    logic [TAB_AW-1:0]         tab_waddr;
    logic [ADDR_W-1:0]         tab_wdata;
    logic                      do_alloc;
    logic                      do_user;

    logic                      res_en;
    logic [1:0]                res_status;
    logic [ADDR_W-1:0]         res_phys;
    logic                      res_made;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign va_di       = r_va[ADDR_W-1 -: DIR_IDX_W];
    assign va_ti       = r_va[PAGE_SHIFT +: TAB_IDX_W];
    assign dir_present = r_dir_q[SLOT_W];
    assign dir_slot    = r_dir_q[SLOT_W-1:0];
    assign pool_full   = (r_tiu >= TIU_W'(MAX_TABLES));
    assign in_window   = (r_va >= r_od_start) && (r_va < r_od_end);

    // ------------------------------------------------------------------
    // Sequencer: one item at a time, directory read, optional table clear,
    // table read or write where the item needs one, then hand the result to the output register.
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        dir_we     = 1'b0;
        dir_waddr  = r_cnt;
        dir_wdata  = '0;
        tab_we     = 1'b0;
        tab_waddr  = {r_slot, r_cnt};
        tab_wdata  = '0;
        do_alloc   = 1'b0;
        do_user    = 1'b0;
        res_en     = 1'b0;
        res_status = r_res_status;
        res_phys   = r_res_phys;
        res_made   = r_res_made;

        case (r_state)
            S_INIT: begin
                // clear one directory entry a cycle
                dir_we = 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                res_phys = '0;
                res_made = 1'b0;
                if (r_mode == MODE_UNMAP) begin
                    if (dir_present) begin
                        n_state = S_TAB;
                    end else begin
                        res_en     = 1'b1;
                        res_status = ST_NOT_PRESENT;
                    end
                end else if (r_mode == MODE_MAP || (r_mode == MODE_FAULT && in_window)) begin
                    if (dir_present) begin
                        n_state = S_WR;
                    end else if (pool_full) begin
                        res_en     = 1'b1;
                        res_status = ST_EXHAUSTED;
                    end else begin
                        // link the next pool slot, then zero it
                        do_alloc  = 1'b1;
                        dir_we    = 1'b1;
                        dir_waddr = va_di;
                        dir_wdata = {1'b1, r_tiu[SLOT_W-1:0]};
                        n_state   = S_CLR;
                    end
                end else if (r_mode == MODE_FAULT) begin
                    res_en     = 1'b1;
                    res_status = ST_OUTSIDE;
                end else begin
                    // unused item kind: answer ok, change nothing
                    res_en     = 1'b1;
                    res_status = ST_OK;
                end
            end
            S_CLR: begin
                tab_we = 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_WR;
                end
            end
            S_TAB: begin
                res_en   = 1'b1;
                res_made = 1'b0;
                if (r_tab_q[0]) begin
                    // drop the present bit, report frame plus offset
                    tab_we     = 1'b1;
                    tab_waddr  = {r_slot, va_ti};
                    tab_wdata  = {r_tab_q[ADDR_W-1:1], 1'b0};
                    res_status = ST_OK;
                    res_phys   = {r_tab_q[ADDR_W-1:PAGE_SHIFT], r_va[PAGE_SHIFT-1:0]};
                end else begin
                    res_status = ST_NOT_PRESENT;
                    res_phys   = '0;
                end
            end
            S_WR: begin
                tab_we    = 1'b1;
                tab_waddr = {r_slot, va_ti};
                if (r_mode == MODE_MAP) begin
                    tab_wdata = {r_pa[ADDR_W-1:PAGE_SHIFT], r_attrs};
                end else begin
                    tab_wdata = {r_next_user, ATTR_USER_RW};
                    do_user   = 1'b1;
                end
                res_en     = 1'b1;
                res_status = ST_OK;
                res_phys   = '0;
                res_made   = r_made;
            end
            S_DONE: begin
                res_en = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand over the result, or park it until the output register frees
        if (res_en) begin
            n_state = out_free ? S_IDLE : S_DONE;
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write and one registered read port each
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_waddr] <= dir_wdata;
        end
        r_dir_q <= r_dir_mem[i_virt_addr[ADDR_W-1 -: DIR_IDX_W]];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= tab_wdata;
        end
        r_tab_q <= r_tab_mem[{dir_slot, va_ti}];
    end

    // ------------------------------------------------------------------
    // Control state, counters and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_tiu       <= '0;
            r_next_user <= USER_POOL_RST;
            r_od_start  <= OD_START_RST;
            r_od_end    <= OD_END_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // sweep counter wraps back to zero at the end of each sweep
            if (r_state == S_INIT || r_state == S_CLR) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (do_alloc) begin
                r_tiu <= r_tiu + 1'b1;
            end

            // directory base and kernel pool frame leave no visible trace:
            // accept the writes and drop them
            if (i_cfg_we && i_cfg_index == CFG_USER_POOL) begin
                r_next_user <= i_cfg_data[FRAME_W-1:0];
            end else if (do_user) begin
                r_next_user <= r_next_user + 1'b1;
            end
            if (i_cfg_we && i_cfg_index == CFG_OD_START) begin
                r_od_start <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_OD_END) begin
                r_od_end <= i_cfg_data;
            end

            if (res_en && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_va    <= i_virt_addr;
            r_pa    <= i_phys_addr;
            r_attrs <= i_page_attrs;
        end
        if (r_state == S_DIR) begin
            r_slot <= dir_present ? dir_slot : r_tiu[SLOT_W-1:0];
            r_made <= do_alloc;
        end
        if (res_en) begin
            r_res_status <= res_status;
            r_res_phys   <= res_phys;
            r_res_made   <= res_made;
        end
        if (res_en && out_free) begin
            r_out_status <= res_status;
            r_out_phys   <= res_phys;
            r_out_made   <= res_made;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_phys_out      = r_out_phys;
    assign o_table_created = r_out_made;

endmodule
